// ===== rtl/core/cantxs_pkg.sv =====
package cantxs_pkg;

    localparam int NUM_FRAMES = 4;
    localparam int FIDX_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FRAME_W    = 3;
    localparam int KIND_W     = 3;
    localparam int CNT_W      = 16;
    localparam int DATA_W     = 64;
    localparam int PADDR_W    = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 3'd0,
        KIND_WRITE     = 3'd1,
        KIND_READ      = 3'd2,
        KIND_SET_EN    = 3'd3,
        KIND_ACTIVATE  = 3'd4,
        KIND_DISABLE   = 3'd5,
        KIND_DIS_ALL   = 3'd6,
        KIND_INIT      = 3'd7
    } kind_t;

    localparam logic [1:0] REG_CYCLE_PERIODS   = 2'd0;
    localparam logic [1:0] REG_EVENT_INTERVALS = 2'd1;
    localparam logic [1:0] REG_EVENT_REPEATS   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_EMIT
    } state_t;

    // Per-frame counters as seen by the shared tick unit
    typedef struct packed {
        logic             enabled;
        logic [CNT_W-1:0] cycle_count;
        logic [CNT_W-1:0] event_count;
        logic [CNT_W-1:0] sends_left;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] interval;
    } tick_in_t;

    typedef struct packed {
        logic             send;
        logic [CNT_W-1:0] cycle_count;
        logic [CNT_W-1:0] event_count;
        logic [CNT_W-1:0] sends_left;
    } tick_out_t;

    function automatic logic [CNT_W-1:0] lane16(input logic [DATA_W-1:0] word,
                                               input logic [FIDX_W-1:0] idx);
        logic [DATA_W-1:0] sh;
        sh = word >> {idx, 4'b0000};
        return sh[CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/cantxs_tick_unit.sv =====
module cantxs_tick_unit
    import cantxs_pkg::*;
(
    input  tick_in_t  tin,
    output tick_out_t tout
);

    always_comb
    begin
        tout.send        = 1'b0;
        tout.cycle_count = tin.cycle_count;
        tout.event_count = tin.event_count;
        tout.sends_left  = tin.sends_left;
        if (tin.enabled)
        begin
            if (tin.sends_left != '0)
            begin
                if (tin.event_count != '0)
                begin
                    if (tin.event_count == tin.interval)
                    begin
                        tout.send       = 1'b1;
                        tout.sends_left = tin.sends_left - 1'b1;
                    end
                    tout.event_count = tin.event_count - 1'b1;
                end
                else
                begin
                    tout.event_count = tin.interval;
                end
            end
            else if (tin.cycle_count > CNT_W'(1))
            begin
                tout.send        = (tin.cycle_count == tin.period);
                tout.cycle_count = tin.cycle_count - 1'b1;
            end
            else
            begin
                tout.cycle_count = tin.period;
            end
        end
    end

endmodule

// ===== rtl/core/can_tx_cyclic_event_scheduler.sv =====
// Tick: accepted, then every frame passes through the shared tick unit in turn,
// then each transmitting frame's word is emitted, lowest frame first, as the output slot frees.
// Read: accepted, then its word loads into the output register once that register is free.
// All other kinds complete in the accept cycle. One item at a time.
// Reset (rst_n low, asynchronous): counters, payloads and config clear to zero,
// every frame comes up enabled, output register empties.
module can_tx_cyclic_event_scheduler
    import cantxs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [FRAME_W-1:0]  frame,
    input  logic [DATA_W-1:0]   payload,
    input  logic                enable_value,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                is_transmit,
    output logic [FRAME_W-1:0]  out_frame,
    output logic [DATA_W-1:0]   out_payload,
    output logic                last,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // Configuration registers, 64 bits each at byte address 8*i.
    logic [DATA_W-1:0] cycle_periods_reg;
    logic [DATA_W-1:0] event_intervals_reg;
    logic [DATA_W-1:0] event_repeats_reg;

    logic       cfg_write;
    logic [1:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_periods_reg   <= '0;
            event_intervals_reg <= '0;
            event_repeats_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CYCLE_PERIODS:   cycle_periods_reg   <= pwdata;
                REG_EVENT_INTERVALS: event_intervals_reg <= pwdata;
                REG_EVENT_REPEATS:   event_repeats_reg   <= pwdata;
                default:             ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_CYCLE_PERIODS:   prdata = cycle_periods_reg;
            REG_EVENT_INTERVALS: prdata = event_intervals_reg;
            REG_EVENT_REPEATS:   prdata = event_repeats_reg;
            default:             prdata = '0;
        endcase
    end

    // Per-frame state, one flop row per frame.
    logic [CNT_W-1:0]  cycle_count_reg [NUM_FRAMES];
    logic [CNT_W-1:0]  event_count_reg [NUM_FRAMES];
    logic [CNT_W-1:0]  sends_left_reg  [NUM_FRAMES];
    logic [DATA_W-1:0] payload_reg     [NUM_FRAMES];
    logic              enabled_reg     [NUM_FRAMES];

    // Sequencer state.
    state_t                state_reg, state_next;
    logic [FIDX_W-1:0]     idx_reg, idx_next;
    logic [NUM_FRAMES-1:0] mask_reg, mask_next;
    logic                  emit_tx_reg, emit_tx_next;

    // Output register.
    logic              out_valid_reg;
    logic              is_transmit_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic [DATA_W-1:0] out_payload_reg;
    logic              last_reg;

    logic              accept;
    logic              frame_ok;
    logic [FIDX_W-1:0] fi;
    logic              slot_free;
    logic              emit_fire;
    logic [FIDX_W-1:0] sel;
    logic [NUM_FRAMES-1:0] mask_left;
    logic              last_frame;

    tick_in_t  tin;
    tick_out_t tout;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign frame_ok  = (frame < FRAME_W'(NUM_FRAMES));
    assign fi        = frame[FIDX_W-1:0];
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_fire = (state_reg == ST_EMIT) && slot_free;
    assign last_frame = (idx_reg == FIDX_W'(NUM_FRAMES - 1));

    // Shared tick unit: one frame per cycle, indexed by the sequencer.
    always_comb
    begin
        tin.enabled     = enabled_reg[idx_reg];
        tin.cycle_count = cycle_count_reg[idx_reg];
        tin.event_count = event_count_reg[idx_reg];
        tin.sends_left  = sends_left_reg[idx_reg];
        tin.period      = lane16(cycle_periods_reg, idx_reg);
        tin.interval    = lane16(event_intervals_reg, idx_reg);
    end

    cantxs_tick_unit u_tick
    (
        .tin  (tin),
        .tout (tout)
    );

    // Lowest pending frame goes out first.
    always_comb
    begin
        sel = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = FIDX_W'(i);
            end
        end
        mask_left = mask_reg & ~(NUM_FRAMES'(1) << sel);
    end

    // Sequencer: next state and control.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        mask_next    = mask_reg;
        emit_tx_next = emit_tx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_TICK)
                    begin
                        state_next   = ST_TICK;
                        idx_next     = '0;
                        mask_next    = '0;
                        emit_tx_next = 1'b1;
                    end
                    else if (kind == KIND_READ && frame_ok)
                    begin
                        state_next   = ST_EMIT;
                        mask_next    = NUM_FRAMES'(1) << fi;
                        emit_tx_next = 1'b0;
                    end
                end
            end
            ST_TICK:
            begin
                // Record which frames transmit; words go out afterwards.
                mask_next = mask_reg | (NUM_FRAMES'(tout.send) << idx_reg);
                if (last_frame)
                begin
                    state_next = (mask_next != '0) ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    mask_next = mask_left;
                    if (mask_left == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            mask_reg    <= '0;
            emit_tx_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            mask_reg    <= mask_next;
            emit_tx_reg <= emit_tx_next;
        end
    end

    // Frame state updates: tick write-back, or the accepted command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                cycle_count_reg[i] <= '0;
                event_count_reg[i] <= '0;
                sends_left_reg[i]  <= '0;
                payload_reg[i]     <= '0;
                enabled_reg[i]     <= 1'b1;
            end
        end
        else if (state_reg == ST_TICK)
        begin
            cycle_count_reg[idx_reg] <= tout.cycle_count;
            event_count_reg[idx_reg] <= tout.event_count;
            sends_left_reg[idx_reg]  <= tout.sends_left;
        end
        else if (accept)
        begin
            case (kind)
                KIND_WRITE:
                begin
                    if (frame_ok)
                    begin
                        payload_reg[fi] <= payload;
                    end
                end
                KIND_SET_EN:
                begin
                    // Reload the period only on an actual enable change.
                    if (frame_ok && (enable_value != enabled_reg[fi]))
                    begin
                        enabled_reg[fi]     <= enable_value;
                        cycle_count_reg[fi] <= lane16(cycle_periods_reg, fi);
                    end
                end
                KIND_ACTIVATE:
                begin
                    if (frame_ok)
                    begin
                        event_count_reg[fi] <= lane16(event_intervals_reg, fi);
                        sends_left_reg[fi]  <= lane16(event_repeats_reg, fi);
                        enabled_reg[fi]     <= 1'b1;
                    end
                end
                KIND_DISABLE:
                begin
                    if (frame_ok)
                    begin
                        enabled_reg[fi] <= 1'b0;
                    end
                end
                KIND_DIS_ALL:
                begin
                    for (int i = 0; i < NUM_FRAMES; i++)
                    begin
                        enabled_reg[i] <= 1'b0;
                    end
                end
                KIND_INIT:
                begin
                    for (int i = 0; i < NUM_FRAMES; i++)
                    begin
                        cycle_count_reg[i] <= lane16(cycle_periods_reg, FIDX_W'(i));
                        event_count_reg[i] <= '0;
                        sends_left_reg[i]  <= '0;
                        payload_reg[i]     <= '0;
                        enabled_reg[i]     <= 1'b1;
                    end
                end
                default:
                begin
                    // tick and read change no frame state here
                end
            endcase
        end
    end

    // Output register: load a word whenever the slot is free during emit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            is_transmit_reg <= emit_tx_reg;
            out_frame_reg   <= FRAME_W'(sel);
            out_payload_reg <= payload_reg[sel];
            last_reg        <= (mask_left == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_transmit = is_transmit_reg;
    assign out_frame   = out_frame_reg;
    assign out_payload = out_payload_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/core/cantxs_checker.sv =====
module cantxs_checker
    import cantxs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [KIND_W-1:0]  kind,
    input logic [FRAME_W-1:0] frame,
    input logic               out_valid,
    input logic               out_ready,
    input logic               is_transmit,
    input logic [DATA_W-1:0]  out_payload,
    input logic               last
);

    // Hold a stalled word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("stalled result word changed or dropped");

    // A read response is always the only word of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_transmit |-> last)
        else $error("read response not marked last");

    // A tick occupies the block while frames are visited.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_TICK) |=> !in_ready)
        else $error("block ready right after accepting a tick");

    // A valid read keeps the block busy until its word is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_READ) && (frame < FRAME_W'(NUM_FRAMES))
        |=> !in_ready)
        else $error("block ready right after accepting a read");

endmodule

bind can_tx_cyclic_event_scheduler cantxs_checker u_cantxs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .frame       (frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_transmit (is_transmit),
    .out_payload (out_payload),
    .last        (last)
);
